### hw/rtl/psu_pkg.sv
// Package for the PNG scanline unfilter: field widths, register indexes,
// filter codes, the compute-stage record and the Paeth predictor function.
// No dependencies.
package psu_pkg;

    localparam int BYTE_W       = 8;
    localparam int FTYPE_W      = 3;
    localparam int BPP_W        = 4;
    localparam int ROW_BYTES_W  = 13;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int S_TUSER_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 1'd1;

    typedef enum logic [FTYPE_W-1:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // Per-byte control carried from the accept stage to the compute stage.
    typedef struct packed {
        logic [BYTE_W-1:0]  cur;
        logic [FTYPE_W-1:0] ftype;
        logic               first_row;
        logic               row_start;
        logic               last;
    } stage_t;

    // Paeth predictor: pick whichever of a, b, c is closest to a + b - c,
    // ties going to a, then b.
    function automatic logic [BYTE_W-1:0] paeth(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] c
    );
        logic signed [BYTE_W+1:0] d_bc;
        logic signed [BYTE_W+1:0] d_ac;
        logic signed [BYTE_W+1:0] d_abc;
        logic        [BYTE_W+1:0] pa;
        logic        [BYTE_W+1:0] pb;
        logic        [BYTE_W+1:0] pc;
        logic        [BYTE_W-1:0] res;
        d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
        d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
        d_abc = d_bc + d_ac;
        pa = (d_bc  < 0) ? $unsigned(-d_bc)  : $unsigned(d_bc);
        pb = (d_ac  < 0) ? $unsigned(-d_ac)  : $unsigned(d_ac);
        pc = (d_abc < 0) ? $unsigned(-d_abc) : $unsigned(d_abc);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

### hw/rtl/png_scanline_unfilter.sv
// PNG scanline unfilter: rebuilds filtered scanline bytes (none, sub, up,
// average, Paeth) using a line buffer of the previous row.
// Depends on psu_pkg.
//
//  Channel  Direction  Signals                      Contents
//  s_       in         s_tvalid s_tready s_tdata    tdata: filtered_byte
//                      s_tuser                      tuser: filter_type, image_start
//  m_       out        m_tvalid m_tready m_tdata    tdata: recon_byte
//                      m_tlast                      tlast: row_end
//  cfg_     in         cfg_wr_en cfg_index cfg_wdata  0 bytes_per_pixel, 1 row_bytes
//
// One byte per cycle sustained while m_tready stays high; m_tvalid rises once
// the byte has passed the compute-stage register and then the output register.
// The line buffer is read in the accept cycle and written back in the
// compute cycle; a back-to-back access to the same entry is forwarded.
// Reset clears positions, valid flags and windows and sets both registers to one;
// the line buffer needs no clearing pass. A stall on m_ backs up through the output register to s_tready.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES       = 4096,
    parameter int MAX_BYTES_PER_PIXEL = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [psu_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] filtered_byte
    input  logic [psu_pkg::S_TUSER_W-1:0]      s_tuser,   // [2:0] filter_type, [3] image_start
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [psu_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] recon_byte
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int POS_W     = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int WIN_DEPTH = MAX_BYTES_PER_PIXEL;
    localparam int WIN_IDX_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

    typedef logic [psu_pkg::BYTE_W-1:0] byte_t;

    // Configuration
    logic [psu_pkg::BPP_W-1:0]       bpp_reg;
    logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_reg;

    // Accept-side control
    logic [POS_W-1:0] byte_pos_reg;
    logic             first_row_reg;

    // Compute stage
    logic             s1_valid_reg;
    psu_pkg::stage_t  s1_reg;
    logic [POS_W-1:0] s1_pos_reg;
    byte_t            mem_q_reg;
    logic             fwd_hit_reg;
    byte_t            fwd_data_reg;

    // Line buffer and windows
    byte_t prior_mem [MAX_ROW_BYTES];
    byte_t left_win_reg   [WIN_DEPTH];
    byte_t upleft_win_reg [WIN_DEPTH];

    // Output register
    logic  m_valid_reg;
    byte_t m_data_reg;
    logic  m_last_reg;

    // Combinational
    logic [31:0]          rb_m1_wide;
    logic [POS_W-1:0]     rb_m1;
    logic [31:0]          bpp_idx_wide;
    logic [WIN_IDX_W-1:0] bpp_idx;
    logic                 s1_adv;
    logic                 accept;
    logic                 img_start;
    logic [POS_W-1:0]     pos_base;
    logic [POS_W-1:0]     pos_now;
    logic                 first_now;
    logic                 last_now;
    byte_t                a_val;
    byte_t                b_val;
    byte_t                c_val;
    byte_t                b_raw;
    logic [psu_pkg::BYTE_W:0] avg_sum;
    byte_t                recon;
    psu_pkg::stage_t      s1_next;

    // Clamp the configured values into their working ranges.
    always_comb begin
        if (row_bytes_reg == '0) begin
            rb_m1_wide = 32'd0;
        end else if (32'(row_bytes_reg) > 32'(MAX_ROW_BYTES)) begin
            rb_m1_wide = 32'(MAX_ROW_BYTES - 1);
        end else begin
            rb_m1_wide = 32'(row_bytes_reg) - 32'd1;
        end
        rb_m1 = rb_m1_wide[POS_W-1:0];

        if (bpp_reg == '0) begin
            bpp_idx_wide = 32'd0;
        end else if (32'(bpp_reg) > 32'(WIN_DEPTH)) begin
            bpp_idx_wide = 32'(WIN_DEPTH - 1);
        end else begin
            bpp_idx_wide = 32'(bpp_reg) - 32'd1;
        end
        bpp_idx = bpp_idx_wide[WIN_IDX_W-1:0];
    end

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Position of the arriving byte. A position left beyond the row by a
    // register change starts a new row.
    always_comb begin
        img_start = s_tuser[psu_pkg::FTYPE_W];
        pos_base  = img_start ? '0 : byte_pos_reg;
        pos_now   = (pos_base > rb_m1) ? '0 : pos_base;
        first_now = img_start || first_row_reg;
        last_now  = (pos_now == rb_m1);

        s1_next.cur       = s_tdata;
        s1_next.ftype     = s_tuser[psu_pkg::FTYPE_W-1:0];
        s1_next.first_row = first_now;
        s1_next.row_start = (pos_now == '0);
        s1_next.last      = last_now;
    end

    // Reconstruction of the byte in the compute stage.
    always_comb begin
        b_raw   = fwd_hit_reg ? fwd_data_reg : mem_q_reg;
        b_val   = s1_reg.first_row ? '0 : b_raw;
        a_val   = s1_reg.row_start ? '0 : left_win_reg[bpp_idx];
        c_val   = s1_reg.row_start ? '0 : upleft_win_reg[bpp_idx];
        avg_sum = {1'b0, a_val} + {1'b0, b_val};
        unique case (s1_reg.ftype)
            psu_pkg::FILT_SUB:   recon = s1_reg.cur + a_val;
            psu_pkg::FILT_UP:    recon = s1_reg.cur + b_val;
            psu_pkg::FILT_AVG:   recon = s1_reg.cur + avg_sum[psu_pkg::BYTE_W:1];
            psu_pkg::FILT_PAETH: recon = s1_reg.cur + psu_pkg::paeth(a_val, b_val, c_val);
            default:             recon = s1_reg.cur;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg       <= psu_pkg::BPP_W'(1);
            row_bytes_reg <= psu_pkg::ROW_BYTES_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                psu_pkg::REG_BYTES_PER_PIXEL: bpp_reg <= cfg_wdata[psu_pkg::BPP_W-1:0];
                psu_pkg::REG_ROW_BYTES:
                    row_bytes_reg <= cfg_wdata[psu_pkg::ROW_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept stage and compute-stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                byte_pos_reg  <= last_now ? '0 : pos_now + POS_W'(1);
                first_row_reg <= last_now ? 1'b0 : first_now;
                s1_valid_reg  <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg  <= 1'b0;
            end
        end
    end

    // Compute-stage payload. The same entry written back this cycle is
    // forwarded, since the memory read would return the old byte.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg       <= s1_next;
            s1_pos_reg   <= pos_now;
            fwd_hit_reg  <= s1_adv && (s1_pos_reg == pos_now);
            fwd_data_reg <= recon;
        end
    end

    // Line buffer: read at accept, written back when the byte is finished.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mem_q_reg <= prior_mem[pos_now];
        end
        if (s1_adv) begin
            prior_mem[s1_pos_reg] <= recon;
        end
    end

    // Left and upper-left windows shift once per finished byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                left_win_reg[i]   <= '0;
                upleft_win_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            for (int i = 1; i < WIN_DEPTH; i++) begin
                left_win_reg[i]   <= s1_reg.row_start ? '0 : left_win_reg[i-1];
                upleft_win_reg[i] <= s1_reg.row_start ? '0 : upleft_win_reg[i-1];
            end
            left_win_reg[0]   <= recon;
            upleft_win_reg[0] <= b_val;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= recon;
            m_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

### bench/testbench.sv
// Self-checking bench for png_scanline_unfilter: reset defaults, directed rows per
// filter type, register clamps, row shrink and a long clamped row, then random images.
// Depends on psu_pkg and the png_scanline_unfilter RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int ROW_LIMIT   = 4096;
    localparam int PIXEL_LIMIT = 8;
    localparam int LONG_RUN    = 512;
    localparam int CYCLE_LIMIT = 1_500_000;

    typedef logic [psu_pkg::BYTE_W-1:0]     byte_t;
    typedef logic [psu_pkg::FTYPE_W-1:0]    ftype_t;
    typedef logic [psu_pkg::CFG_DATA_W-1:0] cfg_word_t;

    typedef struct {
        byte_t recon;
        logic  row_end;
    } recon_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    byte_t                             s_tdata = '0;     // [7:0] filtered_byte
    logic [psu_pkg::S_TUSER_W-1:0]     s_tuser = '0;     // [2:0] filter_type, [3] image_start
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    byte_t                             m_tdata;          // [7:0] recon_byte
    logic                              m_tlast;
    logic                              cfg_wr_en = 1'b0;
    logic [psu_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
    cfg_word_t                         cfg_wdata = '0;

    // Shadow copy of the block's state and registers.
    bit [psu_pkg::BYTE_W-1:0]          prev_row [ROW_LIMIT];
    bit                                written [ROW_LIMIT];
    bit [psu_pkg::BYTE_W-1:0]          left_win [PIXEL_LIMIT];
    bit [psu_pkg::BYTE_W-1:0]          upleft_win [PIXEL_LIMIT];
    int unsigned                       row_pos = 0;
    bit                                top_row = 1'b1;
    logic [psu_pkg::BPP_W-1:0]         cfg_bpp = 4'd1;
    logic [psu_pkg::ROW_BYTES_W-1:0]   cfg_row_bytes = 13'd1;

    recon_t                 recon_queue [$];
    int                     fail_count = 0;
    int                     mismatch_count = 0;
    int                     cycle_count = 0;
    int                     bytes_sent = 0;
    int                     sink_hold = 0;
    bit                     calm = 1'b0;

    png_scanline_unfilter #(
        .MAX_ROW_BYTES      (ROW_LIMIT),
        .MAX_BYTES_PER_PIXEL(PIXEL_LIMIT)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[png_scanline_unfilter] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none at all in calm phases.
    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic byte_t rand_data();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned eff_bpp();
        if (cfg_bpp == 0) return 1;
        if (cfg_bpp > PIXEL_LIMIT) return PIXEL_LIMIT;
        return 32'(cfg_bpp);
    endfunction

    function automatic int unsigned eff_row_len();
        if (cfg_row_bytes == 0) return 1;
        if (cfg_row_bytes > ROW_LIMIT) return ROW_LIMIT;
        return 32'(cfg_row_bytes);
    endfunction

    // True when the next byte would read a line buffer entry never written.
    function automatic bit reads_unwritten(input logic start);
        int unsigned pos;
        if (start || top_row) return 1'b0;
        pos = (row_pos >= eff_row_len()) ? 0 : row_pos;
        return !written[pos];
    endfunction

    function automatic byte_t paeth_pick(
        input byte_t a,
        input byte_t b,
        input byte_t c
    );
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da = (est >= int'(a)) ? est - int'(a) : int'(a) - est;
        db = (est >= int'(b)) ? est - int'(b) : int'(b) - est;
        dc = (est >= int'(c)) ? est - int'(c) : int'(c) - est;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Rebuilds one byte and advances the shadow state; returns {row_end, byte}.
    function automatic logic [psu_pkg::BYTE_W:0] unfilter_byte(
        input byte_t  data,
        input ftype_t ftype,
        input logic   start
    );
        int unsigned              bpp;
        int unsigned              len;
        int unsigned              pos;
        int                       i;
        byte_t                    a;
        byte_t                    b;
        byte_t                    c;
        byte_t                    r;
        logic [psu_pkg::BYTE_W:0] avg;
        logic                     last;
        bpp = eff_bpp();
        len = eff_row_len();
        if (start) begin
            row_pos = 0;
            top_row = 1'b1;
        end
        if (row_pos >= len) row_pos = 0;
        pos = row_pos;
        if (pos == 0) begin
            for (i = 0; i < PIXEL_LIMIT; i++) begin
                left_win[i] = '0;
                upleft_win[i] = '0;
            end
        end
        a = left_win[bpp-1];
        c = upleft_win[bpp-1];
        b = top_row ? 8'h00 : prev_row[pos];
        avg = ({1'b0, a} + {1'b0, b}) >> 1;
        case (ftype)
            psu_pkg::FILT_SUB:   r = data + a;
            psu_pkg::FILT_UP:    r = data + b;
            psu_pkg::FILT_AVG:   r = data + avg[psu_pkg::BYTE_W-1:0];
            psu_pkg::FILT_PAETH: r = data + paeth_pick(a, b, c);
            default:             r = data;
        endcase
        prev_row[pos] = r;
        written[pos] = 1'b1;
        for (i = PIXEL_LIMIT - 1; i > 0; i--) begin
            left_win[i] = left_win[i-1];
            upleft_win[i] = upleft_win[i-1];
        end
        left_win[0] = r;
        upleft_win[0] = b;
        last = (pos == len - 1);
        if (last) begin
            row_pos = 0;
            top_row = 1'b0;
        end else begin
            row_pos = pos + 1;
        end
        return {last, r};
    endfunction

    task automatic send_byte(
        input byte_t  data,
        input ftype_t ftype,
        input logic   start
    );
        int     gap;
        recon_t want;
        gap = pick_gap();
        // Never let the block read a line buffer entry it has not written.
        if (reads_unwritten(start)) start = 1'b1;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {start, ftype};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        {want.row_end, want.recon} = unfilter_byte(data, ftype, start);
        recon_queue.push_back(want);
        bytes_sent++;
    endtask

    task automatic send_row(input int len, input ftype_t ftype, input logic start);
        int k;
        for (k = 0; k < len; k++) send_byte(rand_data(), ftype, start && (k == 0));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (recon_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [psu_pkg::CFG_INDEX_W-1:0] index,
                             input cfg_word_t value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == psu_pkg::REG_BYTES_PER_PIXEL) cfg_bpp = value[psu_pkg::BPP_W-1:0];
        else cfg_row_bytes = value[psu_pkg::ROW_BYTES_W-1:0];
    endtask

    task automatic set_config(input int bpp, input int row_len);
        write_reg(psu_pkg::REG_BYTES_PER_PIXEL, cfg_word_t'(bpp));
        write_reg(psu_pkg::REG_ROW_BYTES, cfg_word_t'(row_len));
    endtask

    // Receiver side: random back-pressure.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= pick_gap();
        end
    end

    // Every output transfer is matched against the oldest predicted byte.
    always @(posedge aclk) begin
        recon_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (recon_queue.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected output transfer: byte %02h last %0b", m_tdata, m_tlast);
            end else begin
                want = recon_queue.pop_front();
                if (m_tdata !== want.recon || m_tlast !== want.row_end) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("output mismatch: expected byte %02h last %0b, got %02h %0b",
                                 want.recon, want.row_end, m_tdata, m_tlast);
                end
            end
        end
    end

    // Reset values: one-byte rows, so every byte ends a row.
    task automatic test_reset_defaults();
        send_byte(8'hFF, psu_pkg::FILT_UP, 1'b1);
        send_byte(8'h01, psu_pkg::FILT_UP, 1'b0);
        send_byte(8'h80, psu_pkg::FILT_PAETH, 1'b0);
    endtask

    // One row per filter code, the unused codes included.
    task automatic test_filter_types();
        int f;
        wait_idle();
        set_config(1, 3);
        for (f = 0; f < (1 << psu_pkg::FTYPE_W); f++) begin
            send_byte(8'hFF, ftype_t'(f), f == 0);
            send_byte(8'h00, ftype_t'(f), 1'b0);
            send_byte(rand_data(), ftype_t'(f), 1'b0);
        end
    endtask

    // Zero and oversize register values act as the nearest legal value.
    task automatic test_range_clamps();
        wait_idle();
        set_config(0, 0);
        send_row(3, psu_pkg::FILT_SUB, 1'b1);
        wait_idle();
        set_config(9, 10);
        send_row(10, psu_pkg::FILT_SUB, 1'b1);
        send_row(4, psu_pkg::FILT_PAETH, 1'b0);
    endtask

    // A shorter row length leaves the position past the row end.
    task automatic test_row_shrink();
        wait_idle();
        set_config(2, 6);
        send_row(6, psu_pkg::FILT_AVG, 1'b1);
        send_row(4, psu_pkg::FILT_PAETH, 1'b0);
        wait_idle();
        set_config(2, 3);
        send_row(3, psu_pkg::FILT_UP, 1'b0);
    endtask

    // The largest register values clamp to the widest pixel and the longest
    // row; a long run stays inside that row and then goes on at the maximums.
    task automatic test_row_limit();
        wait_idle();
        set_config((1 << psu_pkg::BPP_W) - 1, (1 << psu_pkg::ROW_BYTES_W) - 1);
        send_row(LONG_RUN, psu_pkg::FILT_SUB, 1'b1);
        wait_idle();
        set_config(PIXEL_LIMIT, ROW_LIMIT);
        send_row(16, psu_pkg::FILT_PAETH, 1'b0);
    endtask

    task automatic test_random_images();
        int     target;
        int     roll;
        int     bpp;
        int     row_len;
        int     rows;
        int     r;
        int     k;
        int     cut;
        logic   fresh;
        ftype_t ftype;
        target = bytes_sent + 1400;
        while (bytes_sent < target) begin
            wait_idle();
            calm = ($urandom_range(0, 4) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 85) bpp = $urandom_range(1, PIXEL_LIMIT);
            else if (roll < 92) bpp = 0;
            else bpp = $urandom_range(PIXEL_LIMIT + 1, (1 << psu_pkg::BPP_W) - 1);
            roll = $urandom_range(0, 99);
            if (roll < 80) row_len = $urandom_range(1, 24);
            else if (roll < 95) row_len = $urandom_range(25, 200);
            else if (roll < 97) row_len = 0;
            else row_len = $urandom_range(201, 600);
            set_config(bpp, row_len);
            rows = (eff_row_len() > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            fresh = ($urandom_range(0, 3) != 0);
            for (r = 0; r < rows; r++) begin
                if ($urandom_range(0, 99) < 85) begin
                    if ($urandom_range(0, 99) < 85)
                        ftype = ftype_t'($urandom_range(psu_pkg::FILT_NONE,
                                                        psu_pkg::FILT_PAETH));
                    else
                        ftype = ftype_t'($urandom_range(psu_pkg::FILT_PAETH + 1,
                                                        (1 << psu_pkg::FTYPE_W) - 1));
                    send_row(int'(eff_row_len()), ftype, fresh && (r == 0));
                end else begin
                    // Broken row: mixed filter codes, stray image starts, cut short.
                    cut = $urandom_range(1, eff_row_len());
                    for (k = 0; k < cut; k++)
                        send_byte(rand_data(),
                                  ftype_t'($urandom_range(0, (1 << psu_pkg::FTYPE_W) - 1)),
                                  $urandom_range(0, 7) == 0);
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_filter_types();
        test_range_clamps();
        test_row_shrink();
        test_row_limit();
        test_random_images();
        wait_idle();
        repeat (8) @(posedge aclk);
        fail_count += recon_queue.size();
        if (fail_count == 0) begin
            $display("[png_scanline_unfilter] OK");
        end else begin
            $display("[png_scanline_unfilter] ERROR");
        end
        $finish;
    end

endmodule
